/* design/dsvs_pkg.sv */
// ----------------------------------------------------------------------------
// dsvs_pkg
// Shared types and constants for the deduplicating sorted value set.
// ----------------------------------------------------------------------------
package dsvs_pkg;

    localparam int VALUE_W     = 10;
    localparam int COUNT_W     = 11;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_FETCH  = 1'b1
    } action_t;

    typedef struct packed {
        action_t              action;
        logic [VALUE_W-1:0]   value;
        logic                 in_range;
    } cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

endpackage

/* design/dsvs_front.sv */
// ----------------------------------------------------------------------------
// dsvs_front
// Accepts input items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module dsvs_front #(
    parameter int VALUE_RANGE = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [dsvs_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [9:0] value
    input  logic                             s_axis_tuser,   // [0] action
    output logic                             cmd_valid,
    input  logic                             cmd_ready,
    output dsvs_pkg::cmd_t                   cmd
);

    dsvs_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push, pop;
    dsvs_pkg::cmd_t in_cmd;

    always_comb begin
        in_cmd.action   = dsvs_pkg::action_t'(s_axis_tuser);
        in_cmd.value    = s_axis_tdata[dsvs_pkg::VALUE_W-1:0];
        in_cmd.in_range = (in_cmd.action == dsvs_pkg::ACT_INSERT) &&
                          (32'(in_cmd.value) < 32'(VALUE_RANGE));
    end

    assign s_axis_tready = (cnt_reg != 2'd2);
    assign cmd_valid     = (cnt_reg != 2'd0);
    assign cmd           = q_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* design/dsvs_back.sv */
// ----------------------------------------------------------------------------
// dsvs_back
// Bitmap word memory, read-modify-write sequencer and result register.
// ----------------------------------------------------------------------------
module dsvs_back #(
    parameter int VALUE_RANGE = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  dsvs_pkg::cmd_t                   cmd,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [dsvs_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int FULL_RANGE = 1 << dsvs_pkg::VALUE_W;
    localparam int EFF_RANGE  = (VALUE_RANGE < FULL_RANGE) ? VALUE_RANGE : FULL_RANGE;
    localparam int WORD_W     = (EFF_RANGE < 64) ? EFF_RANGE : 64;
    localparam int NWORDS     = (EFF_RANGE + WORD_W - 1) / WORD_W;
    localparam int WIDX_W     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BIDX_W     = $clog2(WORD_W);
    localparam int VW         = dsvs_pkg::VALUE_W;
    localparam int CW         = dsvs_pkg::COUNT_W;

    function automatic logic [BIDX_W-1:0] low_bit_idx(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] iso;
        logic [BIDX_W-1:0] idx;
        iso = w & (~w + 1'b1);
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            idx = idx | (iso[i] ? BIDX_W'(i) : '0);
        end
        return idx;
    endfunction

    function automatic logic [WIDX_W-1:0] low_word_idx(input logic [NWORDS-1:0] m);
        logic [NWORDS-1:0] iso;
        logic [WIDX_W-1:0] idx;
        iso = m & (~m + 1'b1);
        idx = '0;
        for (int i = 0; i < NWORDS; i++) begin
            idx = idx | (iso[i] ? WIDX_W'(i) : '0);
        end
        return idx;
    endfunction

    logic [WORD_W-1:0]  bitmap_mem [NWORDS];

    dsvs_pkg::state_t   state_reg, state_next;
    dsvs_pkg::cmd_t     cmd_reg;
    logic [WIDX_W-1:0]  widx_reg;
    logic [WORD_W-1:0]  rd_data_reg;
    logic               rd_ok_reg;
    logic [NWORDS-1:0]  row_valid_reg;
    logic [NWORDS-1:0]  nonzero_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic               out_valid_reg;
    logic [VW-1:0]      out_value_reg;
    logic               out_found_reg;
    logic               out_dup_reg;
    logic [CW-1:0]      out_count_reg;

    logic [WIDX_W-1:0]  rd_widx;
    logic               rd_en;
    logic               out_free;
    logic               out_load;
    logic               mem_we;

    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  ins_mask;
    logic [WORD_W-1:0]  fetch_mask;
    logic [BIDX_W-1:0]  fetch_bidx;
    logic               hit;
    logic               exec_we;
    logic [WORD_W-1:0]  new_word;
    logic [VW-1:0]      res_value;
    logic               res_found;
    logic               res_dup;

    // read address: insert uses the value's word, fetch the lowest nonempty word
    always_comb begin
        if (cmd.action == dsvs_pkg::ACT_FETCH) begin
            rd_widx = low_word_idx(nonzero_reg);
        end else if (cmd.in_range) begin
            rd_widx = WIDX_W'(cmd.value >> BIDX_W);
        end else begin
            rd_widx = '0;
        end
    end

    always_comb begin
        word       = rd_ok_reg ? rd_data_reg : '0;
        ins_mask   = WORD_W'(1) << cmd_reg.value[BIDX_W-1:0];
        hit        = |(word & ins_mask);
        fetch_mask = word & (~word + 1'b1);
        fetch_bidx = low_bit_idx(word);
        res_value  = '0;
        res_found  = 1'b0;
        res_dup    = 1'b0;
        exec_we    = 1'b0;
        new_word   = word;
        count_next = count_reg;
        unique case (cmd_reg.action)
            dsvs_pkg::ACT_INSERT: begin
                res_dup  = cmd_reg.in_range && hit;
                exec_we  = cmd_reg.in_range && !hit;
                new_word = word | ins_mask;
                if (exec_we) begin
                    count_next = count_reg + 1'b1;
                end
            end
            dsvs_pkg::ACT_FETCH: begin
                if (count_reg != '0) begin
                    exec_we    = 1'b1;
                    res_found  = 1'b1;
                    new_word   = word & ~fetch_mask;
                    res_value  = (VW'(widx_reg) << BIDX_W) | VW'(fetch_bidx);
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
                exec_we = 1'b0;
            end
        endcase
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dsvs_pkg::ST_IDLE: begin
                if (cmd_valid) begin
                    state_next = dsvs_pkg::ST_EXEC;
                end
            end
            dsvs_pkg::ST_EXEC: begin
                if (out_free) begin
                    state_next = dsvs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dsvs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd_ready = (state_reg == dsvs_pkg::ST_IDLE);
        rd_en     = cmd_ready && cmd_valid;
        out_load  = (state_reg == dsvs_pkg::ST_EXEC) && out_free;
        mem_we    = out_load && exec_we;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dsvs_pkg::ST_IDLE;
            row_valid_reg <= '0;
            nonzero_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mem_we) begin
                row_valid_reg[widx_reg] <= 1'b1;
                nonzero_reg[widx_reg]   <= |new_word;
            end
            if (out_load) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            cmd_reg     <= cmd;
            widx_reg    <= rd_widx;
            rd_data_reg <= bitmap_mem[rd_widx];
            rd_ok_reg   <= row_valid_reg[rd_widx];
        end
        if (mem_we) begin
            bitmap_mem[widx_reg] <= new_word;
        end
        if (out_load) begin
            out_value_reg <= res_value;
            out_found_reg <= res_found;
            out_dup_reg   <= res_dup;
            out_count_reg <= count_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_count_reg, out_dup_reg, out_found_reg, out_value_reg};

endmodule

/* design/dedup_sorted_value_set_unit.sv */
// ----------------------------------------------------------------------------
// dedup_sorted_value_set_unit
// Presence-bitmap set: insert with duplicate detection, fetch-and-remove of the smallest.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                              | tuser
//  s_axis   | in  | value[9:0]                                      | action
//  m_axis   | out | value_out[9:0] found was_duplicate count[10:0]  | -
//
//  In the sequencer an item reads its bitmap word (at most 64 bits) as it
//  leaves the two-entry queue, then updates, writes back and loads the
//  result register; the sequencer takes a new item only after that load.
//  A per-word nonempty mask picks the fetch word. Reset clears per-word
//  valid bits, so there is no clearing pass. A held result stalls the
//  sequencer; the queue takes up to two more items before s_axis_tready drops.
// ----------------------------------------------------------------------------
module dedup_sorted_value_set_unit #(
    parameter int VALUE_RANGE = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [dsvs_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [9:0] value
    input  logic                             s_axis_tuser,   // [0] action
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [dsvs_pkg::M_TDATA_W-1:0]   m_axis_tdata    // value_out, found, dup, count
);

    logic           cmd_valid;
    logic           cmd_ready;
    dsvs_pkg::cmd_t cmd;

    dsvs_front #(
        .VALUE_RANGE (VALUE_RANGE)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    dsvs_back #(
        .VALUE_RANGE (VALUE_RANGE)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    a_found_excl_dup: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[10] |-> !m_axis_tdata[11])
        else $error("found and duplicate both set");

    a_empty_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[10] |-> (m_axis_tdata[9:0] == '0))
        else $error("nonzero value without found");

    a_fetch_not_ranged: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid && (cmd.action == dsvs_pkg::ACT_FETCH) |-> !cmd.in_range)
        else $error("fetch classified as in-range insert");

endmodule
